/* rtl/sem_pkg.sv */
// ----------------------------------------------------------------------------
// Semaphore package
// Shared widths, default parameters, operation codes and control structs for
// the counting semaphore with its queue of blocked threads.
// ----------------------------------------------------------------------------
package sem_pkg;

   localparam int DEF_MAX_THREADS = 32;
   localparam int DEF_COUNT_MAX   = 65535;

   localparam int MODE_W = 2;
   localparam int TID_W  = 5;
   localparam int INIT_W = 16;

   typedef enum logic [MODE_W-1:0] {
      MODE_CREATE = 2'd0,
      MODE_WAIT   = 2'd1,
      MODE_POST   = 2'd2,
      MODE_FREE   = 2'd3
   } mode_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_DRAIN = 1'b1
   } state_type;

   // control broadcast to every queue cell
   typedef struct packed {
      logic             push;
      logic             pop;
      logic             clear;
      logic [TID_W-1:0] push_id;
   } queue_ctl_type;

   // status seen at the ends of the queue
   typedef struct packed {
      logic             head_valid;
      logic [TID_W-1:0] head_id;
      logic             second_valid;
      logic             full;
   } queue_stat_type;

   typedef struct packed {
      logic             status;
      logic             blocked;
      logic             resumed_valid;
      logic [TID_W-1:0] resumed_thread;
      logic             reschedule;
      logic             last;
   } rsp_type;

endpackage

/* rtl/sem_req_if.sv */
// ----------------------------------------------------------------------------
// Semaphore request channel
// Valid/ready channel carrying one semaphore operation per request.
// ----------------------------------------------------------------------------
interface sem_req_if
   import sem_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [TID_W-1:0]  thread_id;
   logic [INIT_W-1:0] init_count;

   modport source (output valid, output mode, output thread_id, output init_count,
                   input ready);
   modport sink   (input valid, input mode, input thread_id, input init_count,
                   output ready);
endinterface

/* rtl/sem_rsp_if.sv */
// ----------------------------------------------------------------------------
// Semaphore result channel
// Valid/ready channel carrying one result per request (several for free).
// ----------------------------------------------------------------------------
interface sem_rsp_if
   import sem_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             status;
   logic             blocked;
   logic             resumed_valid;
   logic [TID_W-1:0] resumed_thread;
   logic             reschedule;
   logic             last;

   modport source (output valid, output status, output blocked, output resumed_valid,
                   output resumed_thread, output reschedule, output last,
                   input ready);
   modport sink   (input valid, input status, input blocked, input resumed_valid,
                   input resumed_thread, input reschedule, input last,
                   output ready);
endinterface

/* rtl/sem_cell.sv */
// ----------------------------------------------------------------------------
// Semaphore queue cell
// One slot of the waiter queue. Pop shifts the neighbor toward the head;
// push fills the first empty slot behind an occupied one.
// ----------------------------------------------------------------------------
module sem_cell
   import sem_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_ctl_type    ctl,
   input  logic             prev_valid,
   input  logic             next_valid,
   input  logic [TID_W-1:0] next_id,
   output logic             valid_out,
   output logic [TID_W-1:0] id_out
);

   logic             valid_ff, valid_in;
   logic [TID_W-1:0] id_ff, id_in;

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.pop) begin
         valid_in = next_valid;
         id_in    = next_id;
      end else if (ctl.push && !valid_ff && prev_valid) begin
         valid_in = 1'b1;
         id_in    = ctl.push_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff <= id_in;
   end

   assign valid_out = valid_ff;
   assign id_out    = id_ff;

endmodule

/* rtl/sem_queue.sv */
// ----------------------------------------------------------------------------
// Semaphore waiter queue
// Row of cells holding blocked thread ids, oldest at cell zero.
// ----------------------------------------------------------------------------
module sem_queue
   import sem_pkg::*;
#(
   parameter int MAX_THREADS = DEF_MAX_THREADS
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_ctl_type  ctl,
   output queue_stat_type stat
);

   logic             vld [MAX_THREADS];
   logic [TID_W-1:0] ids [MAX_THREADS];

   for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
      logic             prev_v;
      logic             next_v;
      logic [TID_W-1:0] next_i;

      if (i == 0) begin : g_first
         assign prev_v = 1'b1;
      end else begin : g_prev
         assign prev_v = vld[i-1];
      end

      if (i == MAX_THREADS - 1) begin : g_tail
         assign next_v = 1'b0;
         assign next_i = '0;
      end else begin : g_next
         assign next_v = vld[i+1];
         assign next_i = ids[i+1];
      end

      sem_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .prev_valid (prev_v),
         .next_valid (next_v),
         .next_id    (next_i),
         .valid_out  (vld[i]),
         .id_out     (ids[i])
      );
   end

   assign stat.head_valid   = vld[0];
   assign stat.head_id      = ids[0];
   assign stat.second_valid = vld[1];
   assign stat.full         = vld[MAX_THREADS-1];

endmodule

/* rtl/counting_semaphore_fifo_waiters.sv */
// ----------------------------------------------------------------------------
// Counting semaphore with FIFO wait queue
// Create, wait, post and free on one semaphore; blocked threads are held in
// a shifting row of cells and released oldest first.
// ----------------------------------------------------------------------------
// Each result is registered in the cycle after its request is accepted; a free
// with waiters instead enters the drain state, which registers its results.
// Throughput: one request per cycle for create, wait and post unless output
// stalls. Free with N waiters emits N results as the cell row shifts, one per
// unstalled cycle; it takes no request until its last result is registered.
// Reset (synchronous): semaphore unused, count zero, queue empty.
module counting_semaphore_fifo_waiters
   import sem_pkg::*;
#(
   parameter int MAX_THREADS = DEF_MAX_THREADS,
   parameter int COUNT_MAX   = DEF_COUNT_MAX
) (
   input  logic     clock,
   input  logic     reset,
   sem_req_if.sink  req_ch,
   sem_rsp_if.source rsp_ch
);

   localparam int CM_W  = $clog2(COUNT_MAX + 1);
   localparam int MT_W  = $clog2(MAX_THREADS + 1);
   localparam int MAG_W = (CM_W > MT_W) ? ((CM_W > INIT_W) ? CM_W : INIT_W)
                                        : ((MT_W > INIT_W) ? MT_W : INIT_W);
   localparam int CNT_W = MAG_W + 1;

   localparam logic signed [CNT_W-1:0] CNT_MAX = CNT_W'(COUNT_MAX);
   localparam logic signed [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   state_type                 state_ff, state_in;
   logic                      in_use_ff, in_use_in;
   logic signed [CNT_W-1:0]   count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   queue_ctl_type             qctl;
   queue_stat_type            qstat;

   logic                      out_free;
   logic                      accept;
   logic signed [CNT_W-1:0]   init_ext;
   logic signed [CNT_W-1:0]   count_inc;

   sem_queue #(
      .MAX_THREADS (MAX_THREADS)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .ctl   (qctl),
      .stat  (qstat)
   );

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) && out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   assign init_ext  = signed'({{(CNT_W-INIT_W){1'b0}}, req_ch.init_count});
   assign count_inc = (count_ff < CNT_MAX) ? count_ff + CNT_ONE : count_ff;

   always_comb begin
      state_in     = state_ff;
      in_use_in    = in_use_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      qctl         = '0;
      qctl.push_id = req_ch.thread_id;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.last  = 1'b1;
               if (mode_type'(req_ch.mode) == MODE_CREATE) begin
                  in_use_in  = 1'b1;
                  count_in   = (init_ext > CNT_MAX) ? CNT_MAX : init_ext;
                  qctl.clear = 1'b1;
               end else if (!in_use_ff) begin
                  rsp_in.status = 1'b1;
               end else begin
                  case (mode_type'(req_ch.mode))
                     MODE_WAIT: begin
                        if (count_ff > 0) begin
                           count_in = count_ff - CNT_ONE;
                        end else if (!qstat.full) begin
                           count_in          = count_ff - CNT_ONE;
                           qctl.push         = 1'b1;
                           rsp_in.blocked    = 1'b1;
                           rsp_in.reschedule = 1'b1;
                        end
                     end
                     MODE_POST: begin
                        count_in = count_inc;
                        if (count_inc <= 0 && qstat.head_valid) begin
                           qctl.pop              = 1'b1;
                           rsp_in.resumed_valid  = 1'b1;
                           rsp_in.resumed_thread = qstat.head_id;
                        end
                     end
                     MODE_FREE: begin
                        if (qstat.head_valid) begin
                           // results come out of the drain state
                           rsp_valid_in = 1'b0;
                           state_in     = ST_DRAIN;
                        end else begin
                           rsp_in.reschedule = 1'b1;
                           in_use_in         = 1'b0;
                           count_in          = '0;
                           qctl.clear        = 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               qctl.pop              = 1'b1;
               rsp_valid_in          = 1'b1;
               rsp_in                = '0;
               rsp_in.resumed_valid  = 1'b1;
               rsp_in.resumed_thread = qstat.head_id;
               if (!qstat.second_valid) begin
                  rsp_in.reschedule = 1'b1;
                  rsp_in.last       = 1'b1;
                  in_use_in         = 1'b0;
                  count_in          = '0;
                  state_in          = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_use_ff    <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_ff.status;
   assign rsp_ch.blocked        = rsp_ff.blocked;
   assign rsp_ch.resumed_valid  = rsp_ff.resumed_valid;
   assign rsp_ch.resumed_thread = rsp_ff.resumed_thread;
   assign rsp_ch.reschedule     = rsp_ff.reschedule;
   assign rsp_ch.last           = rsp_ff.last;

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      qctl.push |-> !qstat.full)
      else $error("push into a full waiter queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      qctl.pop |-> qstat.head_valid)
      else $error("pop from an empty waiter queue");

   a_drain_has_waiter: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> (qstat.head_valid && in_use_ff))
      else $error("drain with no waiter or unused semaphore");

   a_negative_count_has_waiter: assert property (@(posedge clock) disable iff (reset)
      count_ff < 0 |-> qstat.head_valid)
      else $error("negative count with empty waiter queue");

endmodule
